@@ hw/rtl/psmit_pkg.sv @@
package psmit_pkg;

  localparam int NREG_TYPES  = 5;
  localparam int CNT_W       = 16;
  localparam int TIME_W      = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_IVL0   = 3'd1;
  localparam logic [2:0] REG_IVL1   = 3'd2;
  localparam logic [2:0] REG_IVL2   = 3'd3;
  localparam logic [2:0] REG_IVL3   = 3'd4;
  localparam logic [2:0] REG_IVL4   = 3'd5;

  localparam logic [4:0]  ENABLE_RESET = 5'd17;
  localparam logic [15:0] IVL0_RESET   = 16'd100;
  localparam logic [15:0] IVL1_RESET   = 16'd0;
  localparam logic [15:0] IVL2_RESET   = 16'd0;
  localparam logic [15:0] IVL3_RESET   = 16'd0;
  localparam logic [15:0] IVL4_RESET   = 16'd1000;

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_RECORD = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_IDLE,
    BK_EXEC,
    BK_CLEAR
  } back_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  source_index;
    logic [2:0]  msg_type;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic        throttled;
    logic [15:0] sent_total;
    logic [15:0] throttled_total;
  } rsp_t;

  // classified request as it travels from front to back
  typedef struct packed {
    op_t         op;
    logic        in_range;
    logic        check_en;
    logic [15:0] interval;
    logic [5:0]  src;
    logic [2:0]  typ;
    logic [31:0] now;
  } cmd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

endpackage

@@ hw/rtl/psmit_front.sv @@
module psmit_front
  import psmit_pkg::*;
#(
  parameter int SOURCES = 64,
  parameter int TYPES   = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        init_busy,
  input  logic        q_ready,
  output logic        q_push,
  output cmd_t        q_data
);

  logic [4:0]  enable_mask;
  logic [15:0] ivl [NREG_TYPES];
  logic [15:0] ivl_sel;
  logic        en_sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= ENABLE_RESET;
      ivl[0] <= IVL0_RESET;
      ivl[1] <= IVL1_RESET;
      ivl[2] <= IVL2_RESET;
      ivl[3] <= IVL3_RESET;
      ivl[4] <= IVL4_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE: enable_mask <= cfg_data[4:0];
        REG_IVL0:   ivl[0] <= cfg_data[15:0];
        REG_IVL1:   ivl[1] <= cfg_data[15:0];
        REG_IVL2:   ivl[2] <= cfg_data[15:0];
        REG_IVL3:   ivl[3] <= cfg_data[15:0];
        REG_IVL4:   ivl[4] <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // types without an interval register never throttle
  always_comb begin
    ivl_sel = '0;
    en_sel  = 1'b0;
    for (int i = 0; i < NREG_TYPES; i++) begin
      if (req_data.msg_type == 3'(i)) begin
        ivl_sel = ivl[i];
        en_sel  = enable_mask[i];
      end
    end
  end

  assign req_ready = q_ready && !init_busy;
  assign q_push    = req_valid && req_ready;

  always_comb begin
    q_data          = '0;
    q_data.op       = op_t'(req_data.kind);
    q_data.in_range = (32'(req_data.source_index) < SOURCES) &&
                      (32'(req_data.msg_type) < TYPES);
    q_data.check_en = en_sel && (ivl_sel != '0);
    q_data.interval = ivl_sel;
    q_data.src      = req_data.source_index;
    q_data.typ      = req_data.msg_type;
    q_data.now      = req_data.now_ms;
  end

endmodule

@@ hw/rtl/psmit_queue.sv @@
module psmit_queue
  import psmit_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic ready,
  output logic valid,
  output cmd_t head,
  input  logic pop
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign ready   = count != QCNT_W'(QUEUE_DEPTH);
  assign valid   = count != '0;
  assign head    = slots[rp];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop)  rp <= rp + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wp] <= push_data;
  end

endmodule

@@ hw/rtl/psmit_back.sv @@
module psmit_back
  import psmit_pkg::*;
#(
  parameter int SOURCES = 64,
  parameter int TYPES   = 5
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_head,
  output logic q_pop,
  output logic init_busy,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  localparam int SRC_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int TYP_W  = (TYPES > 1) ? $clog2(TYPES) : 1;
  localparam int ADDR_W = SRC_W + TYP_W;
  localparam int DEPTH  = 2 ** ADDR_W;

  // entry {sent, held} in cnt_mem, last send time in time_mem
  logic [TIME_W-1:0]  time_mem [DEPTH];
  logic [2*CNT_W-1:0] cnt_mem  [DEPTH];

  back_state_t        state, state_next;
  logic [ADDR_W-1:0]  sweep, sweep_next;
  cmd_t               cur;
  logic [TIME_W-1:0]  time_rd;
  logic [2*CNT_W-1:0] cnt_rd;
  logic               out_valid;
  rsp_t               out_data;

  logic [ADDR_W-1:0]  raddr, waddr, cur_addr;
  logic               rd_en, t_we, c_we, rsp_load, out_free;
  logic [TIME_W-1:0]  t_wdata;
  logic [2*CNT_W-1:0] c_wdata;
  rsp_t               rsp_next;
  logic [TIME_W-1:0]  diff;
  logic               held;
  logic [CNT_W-1:0]   sc, hc;

  assign raddr     = {SRC_W'(q_head.src), TYP_W'(q_head.typ)};
  assign cur_addr  = {SRC_W'(cur.src), TYP_W'(cur.typ)};
  assign out_free  = !out_valid || rsp_ready;
  assign init_busy = (state == BK_INIT);
  assign rsp_valid = out_valid;
  assign rsp_data  = out_data;

  // a negative signed difference always throttles
  assign diff = cur.now - time_rd;
  assign held = cur.check_en &&
                (diff[TIME_W-1] || (diff < TIME_W'(cur.interval)));
  assign sc   = cnt_rd[2*CNT_W-1:CNT_W];
  assign hc   = cnt_rd[CNT_W-1:0];

  always_comb begin
    state_next = state;
    sweep_next = sweep;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    t_we       = 1'b0;
    c_we       = 1'b0;
    waddr      = cur_addr;
    t_wdata    = cur.now;
    c_wdata    = '0;
    rsp_load   = 1'b0;
    rsp_next   = '0;
    case (state)
      BK_INIT: begin
        t_we       = 1'b1;
        c_we       = 1'b1;
        waddr      = sweep;
        t_wdata    = '0;
        sweep_next = sweep + 1'b1;
        if (&sweep) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          rd_en = 1'b1;
          state_next = (q_head.op == OP_CLEAR) ? BK_CLEAR : BK_EXEC;
        end
      end
      BK_CLEAR: begin
        c_we       = 1'b1;
        waddr      = sweep;
        sweep_next = sweep + 1'b1;
        if (&sweep) state_next = BK_EXEC;
      end
      BK_EXEC: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = BK_IDLE;
        end
        if (cur.in_range) begin
          rsp_next.sent_total      = sc;
          rsp_next.throttled_total = hc;
          case (cur.op)
            OP_CHECK: begin
              if (cur.check_en) begin
                c_we = rsp_load;
                rsp_next.throttled = held;
                if (held) rsp_next.throttled_total = sat_inc(hc);
                else      rsp_next.sent_total      = sat_inc(sc);
              end
            end
            OP_RECORD: begin
              t_we = rsp_load;
              c_we = rsp_load;
              rsp_next.sent_total = sat_inc(sc);
            end
            OP_QUERY: ;
            OP_CLEAR: rsp_next = '0;
            default: rsp_next = '0;
          endcase
          c_wdata = {rsp_next.sent_total, rsp_next.throttled_total};
        end
      end
      default: state_next = BK_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_INIT;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sweep <= sweep_next;
      if (rsp_load)       out_valid <= 1'b1;
      else if (rsp_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop)    cur      <= q_head;
    if (rsp_load) out_data <= rsp_next;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      time_rd <= time_mem[raddr];
      cnt_rd  <= cnt_mem[raddr];
    end
    if (t_we) time_mem[waddr] <= t_wdata;
    if (c_we) cnt_mem[waddr]  <= c_wdata;
  end

endmodule

@@ hw/rtl/per_source_min_interval_throttle_top.sv @@
// Per-source minimum-interval throttle.
// req channel: one request per handshake (check, record, query, clear) for a
// source and message type. rsp channel: one result per request, in order.
// cfg channel: register writes (enable mask, then five intervals), always
// ready; write only while no request is outstanding.
// A taken request passes the queue, the table read and the output register.
// The back end takes no new request before it is through with the last:
// it reads one table entry, then updates it, in the synchronous memories.
// A clear request sweeps every counter, one entry a cycle, over 2**A entries,
// A = clog2(SOURCES) + clog2(TYPES) (512 entries at the defaults).
// Reset: the same sweep clears times and counters (512 entries at the
// defaults); req_ready stays low until it is done. Config regs go to reset.
// Stall: a finished response waits in the output register, the back end holds
// the next request and up to two more queue up; req_ready drops when full.
module per_source_min_interval_throttle_top
  import psmit_pkg::*;
#(
  parameter int SOURCES = 64,
  parameter int TYPES   = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req_data,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic init_busy;
  logic q_ready, q_push, q_valid, q_pop;
  cmd_t q_in, q_head;

  psmit_front #(.SOURCES(SOURCES), .TYPES(TYPES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .init_busy (init_busy),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  psmit_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .ready     (q_ready),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  psmit_back #(.SOURCES(SOURCES), .TYPES(TYPES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import psmit_pkg::*;

  localparam int N_SRC       = 64;
  localparam int N_TYPE      = 5;
  localparam int N_ENT       = N_SRC * N_TYPE;
  localparam int RAND_ITEMS  = 2000;
  localparam int PHASES      = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_PRINTS  = 50;

  // indexes past the last interval register; writes there must be dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    req_t r;
    bit   fixed;
    rsp_t want;
  } probe_t;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req_data;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // shadow of the throttle table and its registers
  logic [31:0] last_ms [N_ENT];
  logic [15:0] sends   [N_ENT];
  logic [15:0] holds   [N_ENT];
  logic [4:0]  type_en;
  logic [15:0] min_gap [NREG_TYPES];

  rsp_t        want_q[$];
  int          mismatches = 0;
  int          quiet = 0;
  bit          idle_on = 1'b1;
  bit          rsp_hold_go = 1'b0;
  logic [31:0] clock_ms = '0;

  per_source_min_interval_throttle_top #(
    .SOURCES(N_SRC),
    .TYPES  (N_TYPE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic rsp_t throttle_predict(input req_t r);
    rsp_t        o;
    int          e;
    logic [31:0] diff;
    logic        hit;
    o   = '0;
    hit = 1'b0;
    if (op_t'(r.kind) == OP_CLEAR) begin
      // counters only; send times survive a clear
      for (int i = 0; i < N_ENT; i++) begin
        sends[i] = '0;
        holds[i] = '0;
      end
      return o;
    end
    if (r.source_index >= N_SRC || r.msg_type >= N_TYPE) return o;
    e = r.source_index * N_TYPE + r.msg_type;
    case (op_t'(r.kind))
      OP_CHECK: begin
        if (type_en[r.msg_type] && min_gap[r.msg_type] != 16'd0) begin
          diff = r.now_ms - last_ms[e];
          hit  = diff[31] || (diff < {16'd0, min_gap[r.msg_type]});
          if (hit) holds[e] = bump(holds[e]);
          else sends[e] = bump(sends[e]);
        end
      end
      OP_RECORD: begin
        last_ms[e] = r.now_ms;
        sends[e]   = bump(sends[e]);
      end
      default: ;
    endcase
    o.throttled       = hit;
    o.sent_total      = sends[e];
    o.throttled_total = holds[e];
    return o;
  endfunction

  function automatic void cfg_apply(input logic [2:0] idx, input logic [31:0] v);
    if (idx == REG_ENABLE) type_en = v[4:0];
    else if (idx <= REG_IVL4) min_gap[idx - REG_IVL0] = v[15:0];
  endfunction

  function automatic probe_t probe(input op_t k, input int src, input int typ,
                                   input logic [31:0] now, input bit fx,
                                   input bit thr, input int snt, input int hld);
    probe_t p;
    p.r.kind                 = k;
    p.r.source_index         = 6'(src);
    p.r.msg_type             = 3'(typ);
    p.r.now_ms               = now;
    p.fixed                  = fx;
    p.want.throttled         = thr;
    p.want.sent_total        = 16'(snt);
    p.want.throttled_total   = 16'(hld);
    return p;
  endfunction

  function automatic req_t draw_request();
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 45) r.kind = OP_CHECK;
    else if (pick < 80) r.kind = OP_RECORD;
    else if (pick < 97) r.kind = OP_QUERY;
    else r.kind = OP_CLEAR;
    // a few busy sources so entries get revisited
    if ($urandom_range(99) < 75) r.source_index = 6'($urandom_range(3));
    else r.source_index = 6'($urandom);
    if ($urandom_range(99) < 90) r.msg_type = 3'($urandom_range(4));
    else r.msg_type = 3'($urandom_range(7, 5));
    pick = $urandom_range(99);
    if (pick < 8) begin
      r.now_ms = $urandom;
    end else if (pick < 14) begin
      r.now_ms = clock_ms - $urandom_range(200, 1);
    end else begin
      clock_ms = clock_ms + $urandom_range(150);
      r.now_ms = clock_ms;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp_v);
    if (mismatches < MAX_PRINTS)
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, exp_v);
    mismatches++;
  endtask

  task automatic send_req(input req_t r, input bit fixed, input rsp_t want);
    rsp_t pred;
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    pred = throttle_predict(r);
    want_q.push_back(fixed ? want : pred);
    if (idle_on && $urandom_range(99) < 25) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_apply(idx, v);
  endtask

  task automatic drain_all();
    req_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_phase(input int p);
    logic [31:0] v;
    logic [15:0] gap;
    drain_all();
    v = $urandom;
    if (p == 0) v[4:0] = 5'h1F;
    else if (p == 1) v[4:0] = 5'h00;
    write_reg(REG_ENABLE, v);
    for (int i = 0; i < NREG_TYPES; i++) begin
      case ($urandom_range(3))
        0: gap = 16'd0;
        1: gap = 16'($urandom_range(40, 1));
        2: gap = 16'($urandom_range(400, 40));
        default: gap = 16'($urandom);
      endcase
      if (p == 0) gap = 16'hFFFF;
      else if (p == 1) gap = 16'd0;
      v       = $urandom;
      v[15:0] = gap;
      write_reg(REG_IVL0 + 3'(i), v);
    end
    write_reg(p[0] ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // response side
  initial begin
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold_go) begin
        rsp_hold_go = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ready <= (idle_on && $urandom_range(99) < 25) ? 1'b0 : 1'b1;
    end
  end

  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && rsp_valid && rsp_ready) begin
      if (want_q.size() == 0) begin
        note_mismatch("response with no request pending",
                      {rsp_data.sent_total, rsp_data.throttled_total}, '0);
      end else begin
        exp_r = want_q.pop_front();
        if (rsp_data.throttled !== exp_r.throttled)
          note_mismatch("throttled", 32'(rsp_data.throttled),
                        32'(exp_r.throttled));
        if (rsp_data.sent_total !== exp_r.sent_total)
          note_mismatch("sent_total", 32'(rsp_data.sent_total),
                        32'(exp_r.sent_total));
        if (rsp_data.throttled_total !== exp_r.throttled_total)
          note_mismatch("throttled_total", 32'(rsp_data.throttled_total),
                        32'(exp_r.throttled_total));
      end
    end
  end

  // stall watchdog; its limit covers the sweeps after reset and a clear
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    probe_t probes[$];
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_data  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    type_en    = ENABLE_RESET;
    min_gap[0] = IVL0_RESET;
    min_gap[1] = IVL1_RESET;
    min_gap[2] = IVL2_RESET;
    min_gap[3] = IVL3_RESET;
    min_gap[4] = IVL4_RESET;
    for (int i = 0; i < N_ENT; i++) begin
      last_ms[i] = '0;
      sends[i]   = '0;
      holds[i]   = '0;
    end

    // reset register values: type 0 at 100 ms, type 4 at 1000 ms
    probes.push_back(probe(OP_QUERY,   0, 0, 32'h0,        1, 0, 0, 0));
    probes.push_back(probe(OP_CHECK,   0, 0, 32'd50,       1, 1, 0, 1));
    probes.push_back(probe(OP_CHECK,   0, 0, 32'd100,      1, 0, 1, 1));
    probes.push_back(probe(OP_CHECK,   1, 1, 32'd5,        1, 0, 0, 0));
    probes.push_back(probe(OP_RECORD, 63, 4, 32'hFFFFFFFF, 1, 0, 1, 0));
    // clock wrap: a tiny positive gap
    probes.push_back(probe(OP_CHECK,  63, 4, 32'h0,        1, 1, 1, 1));
    // gap with the sign bit set reads as negative
    probes.push_back(probe(OP_CHECK,  63, 4, 32'h7FFFFFFF, 1, 1, 1, 2));
    probes.push_back(probe(OP_CHECK,  63, 4, 32'h7FFFFFFE, 1, 0, 2, 2));
    probes.push_back(probe(OP_RECORD,  5, 7, 32'h12345678, 1, 0, 0, 0));
    probes.push_back(probe(OP_CHECK,   5, 5, 32'h0,        1, 0, 0, 0));
    probes.push_back(probe(OP_QUERY,   5, 6, 32'hFFFFFFFF, 1, 0, 0, 0));
    probes.push_back(probe(OP_RECORD,  0, 2, 32'hAAAAAAAA, 1, 0, 1, 0));
    probes.push_back(probe(OP_QUERY,  63, 4, 32'h0,        1, 0, 2, 2));
    probes.push_back(probe(OP_CLEAR,  42, 3, 32'h55555555, 1, 0, 0, 0));
    probes.push_back(probe(OP_QUERY,  63, 4, 32'h0,        1, 0, 0, 0));
    // send time kept across the clear: gap of exactly the interval
    probes.push_back(probe(OP_CHECK,  63, 4, 32'h000003E7, 1, 0, 1, 0));
    probes.push_back(probe(OP_CHECK,  42, 3, 32'h55555555, 1, 0, 0, 0));
    probes.push_back(probe(OP_QUERY,   0, 0, 32'h0,        1, 0, 0, 0));
    probes.push_back(probe(OP_CHECK,   0, 0, 32'd100,      1, 0, 1, 0));
    probes.push_back(probe(OP_CHECK,   0, 0, 32'd99,       0, 0, 0, 0));
    probes.push_back(probe(OP_RECORD, 21, 0, 32'h80000000, 0, 0, 0, 0));
    probes.push_back(probe(OP_CHECK,  21, 0, 32'h00000000, 0, 0, 0, 0));
    probes.push_back(probe(OP_CHECK,  21, 4, 32'h00000500, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) send_req(probes[i].r, probes[i].fixed, probes[i].want);

    for (int p = 0; p < PHASES; p++) begin
      set_phase(p);
      idle_on = (p != 2);
      if (p == 5) clock_ms = 32'hFFFFFF00;
      // receiver holds off while requests keep coming
      if (p == 3) rsp_hold_go = 1'b1;
      for (int i = 0; i < RAND_ITEMS / PHASES; i++) send_req(draw_request(), 0, '0);
    end

    drain_all();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && want_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
